// File: design/rg32_pkg.sv
// Shared types, sizes and helper functions for the RadioGatun[32] hash block.
// Used by rg32_belt_cell, rg32_mill and radiogatun32_hash. No dependencies.
package rg32_pkg;

  // Sizes of the sponge state
  localparam int MILL_SIZE    = 19;
  localparam int BELT_COLS    = 13;
  localparam int BELT_ROWS    = 3;
  localparam int BLANK_ROUNDS = 17;

  // Digest length: words asked for, and words actually given (at most eight)
  localparam int OUTPUT_WORDS = 8;
  localparam int MAX_RESULTS  = 8;
  localparam int OUT_COUNT    = (OUTPUT_WORDS > MAX_RESULTS) ? MAX_RESULTS : OUTPUT_WORDS;

  // Top-level phases
  localparam logic [1:0] PH_ABSORB = 2'd0;
  localparam logic [1:0] PH_BLANK  = 2'd1;
  localparam logic [1:0] PH_OUT    = 2'd2;

  typedef logic [31:0] word_t;
  typedef word_t [BELT_ROWS-1:0] col_t;
  typedef word_t [MILL_SIZE-1:0] mill_t;

  // Per-cycle commands to the belt cells and the mill
  typedef struct packed {
    logic clear;
    logic inject;
    logic round;
  } rg_ctrl_t;

  function automatic word_t rotr(input word_t x, input logic [4:0] r);
    logic [63:0] d;
    d = {x, x} >> r;
    return d[31:0];
  endfunction

  function automatic word_t swap_bytes(input word_t x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

// File: design/radiogatun32_hash.sv
// RadioGatun[32] hash top level: byte packing, phase control, digest output.
// Depends on rg32_pkg, rg32_belt_cell and rg32_mill.
//
//  channel | signals                              | beat
//  --------+--------------------------------------+-----------------------------
//  in      | in_valid in_ready msg_byte           | one message byte, or the
//          | end_of_message                       | end marker
//  out     | out_valid out_ready hash_word        | one digest word
//          | word_index last                      |
//
// Message bytes are taken one per cycle while in_ready is high; a belt-mill
// round runs in the cycle that completes every third word. An end beat pads
// and injects, then the blank rounds run, then the digest words are loaded
// (the output rounds run in the cycle that loads the even words). in_ready
// drops from the end beat until the last digest word is loaded; a new
// message may start while that word still waits. Output stalls hold the
// output register and stop the sequencer. Reset is synchronous.
module radiogatun32_hash (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          msg_byte,
  input  logic                end_of_message,
  output logic                out_valid,
  input  logic                out_ready,
  output rg32_pkg::word_t     hash_word,
  output logic [2:0]          word_index,
  output logic                last
);
  import rg32_pkg::*;

  logic [1:0] phase;
  logic [4:0] rnd_cnt;
  logic [2:0] k;
  word_t      partial_word;
  logic [1:0] byte_pos;
  logic [1:0] word_pos;

  rg_ctrl_t   ctrl;
  word_t      inj_word;
  logic [1:0] inj_row;
  word_t      packed_word;
  logic       in_fire;
  logic       out_load;
  logic       k_last;

  mill_t      mill_pre;
  mill_t      mill_rnd;
  mill_t      mill_q;
  col_t       cell_out [BELT_COLS];
  col_t       cell_inj [BELT_COLS];
  col_t       cell_feed [BELT_COLS];

  assign in_ready = (phase == PH_ABSORB);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (phase == PH_OUT) && (!out_valid || out_ready);
  assign k_last   = (k == 3'(OUT_COUNT - 1));
  assign inj_row  = (word_pos == 2'd3) ? 2'd0 : word_pos;

  // current byte (or pad byte) merged into the partial word
  always_comb begin
    packed_word = partial_word;
    case (byte_pos)
      2'd1:    packed_word[15:8]  = end_of_message ? 8'h01 : msg_byte;
      2'd2:    packed_word[23:16] = end_of_message ? 8'h01 : msg_byte;
      2'd3:    packed_word[31:24] = end_of_message ? 8'h01 : msg_byte;
      default: packed_word[7:0]   = end_of_message ? 8'h01 : msg_byte;
    endcase
  end

  // commands for this cycle
  always_comb begin
    ctrl     = '0;
    inj_word = packed_word;
    case (phase)
      PH_ABSORB: begin
        if (in_fire) begin
          ctrl.inject = end_of_message || (byte_pos == 2'd3);
          ctrl.round  = !end_of_message && (byte_pos == 2'd3) && (inj_row == 2'd2);
        end
      end
      PH_BLANK: begin
        ctrl.round = 1'b1;
      end
      PH_OUT: begin
        if (out_load) begin
          ctrl.round = !k[0];
          ctrl.clear = k_last;
        end
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  // belt ring: injection at column 0, mill feed into columns 0..11
  for (genvar j = 0; j < BELT_COLS; j++) begin : g_belt
    for (genvar r = 0; r < BELT_ROWS; r++) begin : g_row
      if (j == 0) begin : g_inj
        assign cell_inj[j][r] = (ctrl.inject && inj_row == 2'(r)) ? inj_word : '0;
      end else begin : g_noinj
        assign cell_inj[j][r] = '0;
      end
      if (j < BELT_COLS - 1 && (j % BELT_ROWS) == r) begin : g_feed
        assign cell_feed[j][r] = mill_pre[j + 1];
      end else begin : g_nofeed
        assign cell_feed[j][r] = '0;
      end
    end

    rg32_belt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl),
      .inj  (cell_inj[j]),
      .feed (cell_feed[j]),
      .prev (cell_out[(j + BELT_COLS - 1) % BELT_COLS]),
      .nxt  (cell_out[j])
    );
  end

  rg32_mill u_mill (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .inj_word (inj_word),
    .inj_row  (inj_row),
    .belt_in  (cell_out[BELT_COLS - 1]),
    .mill_pre (mill_pre),
    .mill_rnd (mill_rnd),
    .mill_q   (mill_q)
  );

  // phase sequencer and byte packing
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_ABSORB;
      rnd_cnt      <= '0;
      k            <= '0;
      partial_word <= '0;
      byte_pos     <= '0;
      word_pos     <= '0;
    end else begin
      case (phase)
        PH_ABSORB: begin
          if (in_fire) begin
            if (end_of_message) begin
              partial_word <= '0;
              byte_pos     <= '0;
              word_pos     <= '0;
              rnd_cnt      <= '0;
              phase        <= PH_BLANK;
            end else begin
              byte_pos <= byte_pos + 2'd1;
              if (byte_pos == 2'd3) begin
                partial_word <= '0;
                word_pos     <= (inj_row == 2'd2) ? 2'd0 : inj_row + 2'd1;
              end else begin
                partial_word <= packed_word;
              end
            end
          end
        end
        PH_BLANK: begin
          rnd_cnt <= rnd_cnt + 5'd1;
          if (rnd_cnt == 5'(BLANK_ROUNDS - 1)) begin
            k     <= '0;
            phase <= PH_OUT;
          end
        end
        PH_OUT: begin
          if (out_load) begin
            if (k_last) begin
              phase <= PH_ABSORB;
            end else begin
              k <= k + 3'd1;
            end
          end
        end
        default: begin
          phase <= PH_ABSORB;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      hash_word  <= swap_bytes(k[0] ? mill_q[2] : mill_rnd[1]);
      word_index <= k;
      last       <= k_last;
    end
  end

  // end beat always starts the blank rounds
  a_end_blocks: assert property (@(posedge clk) disable iff (rst)
    in_fire && end_of_message |=> !in_ready && phase == PH_BLANK)
    else $error("end beat did not start finishing");

  // a fresh word has no stale bytes
  a_partial_clean: assert property (@(posedge clk) disable iff (rst)
    byte_pos == 2'd0 |-> partial_word == '0)
    else $error("partial word not cleared at word boundary");

  // word position stays inside a group of three
  a_word_pos: assert property (@(posedge clk) disable iff (rst)
    word_pos != 2'd3)
    else $error("word position out of range");

  // loading the final word reopens the input and clears the state
  a_last_reopens: assert property (@(posedge clk) disable iff (rst)
    out_load && k_last |=> in_ready && last && out_valid && mill_q == '0)
    else $error("digest end did not restore absorb state");

endmodule

// File: design/rg32_belt_cell.sv
// One belt column (three rows) of the RadioGatun[32] belt.
// Depends on rg32_pkg. Cells form a ring that rotates by one on each round.
module rg32_belt_cell (
  input  logic            clk,
  input  logic            rst,
  input  rg32_pkg::rg_ctrl_t ctrl,
  input  rg32_pkg::col_t  inj,
  input  rg32_pkg::col_t  feed,
  input  rg32_pkg::col_t  prev,
  output rg32_pkg::col_t  nxt
);
  import rg32_pkg::*;

  col_t q;

  // value handed to the neighbor: after word injection and mill feed
  assign nxt = q ^ inj ^ feed;

  // round takes the left neighbor's column; inject only merges the word
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      q <= '0;
    end else if (ctrl.round) begin
      q <= prev;
    end else if (ctrl.inject) begin
      q <= q ^ inj;
    end
  end

endmodule

// File: design/rg32_mill.sv
// Mill register and the RadioGatun[32] mill round (gamma, pi, theta, iota,
// belt feedback). Depends on rg32_pkg.
module rg32_mill (
  input  logic               clk,
  input  logic               rst,
  input  rg32_pkg::rg_ctrl_t ctrl,
  input  rg32_pkg::word_t    inj_word,
  input  logic [1:0]         inj_row,
  input  rg32_pkg::col_t     belt_in,
  output rg32_pkg::mill_t    mill_pre,
  output rg32_pkg::mill_t    mill_rnd,
  output rg32_pkg::mill_t    mill_q
);
  import rg32_pkg::*;

  word_t t [MILL_SIZE];

  // word injection into mill words 16..18
  always_comb begin
    mill_pre = mill_q;
    if (ctrl.inject) begin
      case (inj_row)
        2'd1:    mill_pre[17] = mill_q[17] ^ inj_word;
        2'd2:    mill_pre[18] = mill_q[18] ^ inj_word;
        default: mill_pre[16] = mill_q[16] ^ inj_word;
      endcase
    end
  end

  // gamma and pi with triangular rotation amounts
  for (genvar i = 0; i < MILL_SIZE; i++) begin : g_gamma
    localparam int P = (7 * i) % MILL_SIZE;
    localparam int R = ((i * (i + 1)) / 2) % 32;
    assign t[i] = rotr(mill_pre[P] ^ (mill_pre[(P + 1) % MILL_SIZE]
                       | ~mill_pre[(P + 2) % MILL_SIZE]), 5'(R));
  end

  // theta, iota and belt feedback into words 13..15
  for (genvar i = 0; i < MILL_SIZE; i++) begin : g_theta
    word_t th;
    assign th = t[i] ^ t[(i + 1) % MILL_SIZE] ^ t[(i + 4) % MILL_SIZE];
    if (i == 0) begin : g_iota
      assign mill_rnd[i] = th ^ 32'd1;
    end else if (i >= BELT_COLS && i < BELT_COLS + BELT_ROWS) begin : g_fb
      assign mill_rnd[i] = th ^ belt_in[i - BELT_COLS];
    end else begin : g_plain
      assign mill_rnd[i] = th;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      mill_q <= '0;
    end else if (ctrl.round) begin
      mill_q <= mill_rnd;
    end else if (ctrl.inject) begin
      mill_q <= mill_pre;
    end
  end

endmodule
